// ===== hw/rtl/box_iou_accuracy_counter_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the box IoU accuracy counter
// Implication checks clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef BOX_IOU_ACCURACY_COUNTER_DEFINES_SVH
`define BOX_IOU_ACCURACY_COUNTER_DEFINES_SVH

// Same-cycle implication.
`define BIAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BIAC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/biac_pkg.sv =====
// ----------------------------------------------------------------------------
// biac_pkg
// Shared types and constants of the box IoU accuracy counter.
// ----------------------------------------------------------------------------
package biac_pkg;

  localparam int CB          = 16;             // coordinate width
  localparam int IN_FIELDS   = 8;
  localparam int IN_BITS     = ((IN_FIELDS * CB + 7) / 8) * 8;
  localparam int PCT_BITS    = 7;
  localparam int CNT_BITS    = 32;
  localparam int OUT_BITS    = ((PCT_BITS + 1 + 2 * CNT_BITS + 7) / 8) * 8;
  localparam int AREA_BITS   = 2 * CB;
  localparam int UNI_BITS    = AREA_BITS + 1;
  localparam int REM_BITS    = UNI_BITS + PCT_BITS - 1;
  localparam int DIV_STEPS   = PCT_BITS;
  localparam int STEP_BITS   = $clog2(DIV_STEPS);
  localparam int PCT_SCALE   = 100;
  localparam int THR_RESET   = 50;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic [CB-1:0]        span_t;
  typedef logic [AREA_BITS-1:0] area_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_I,
    ST_MUL_A,
    ST_MUL_B,
    ST_PREP,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    MUL_INTER,
    MUL_AREA_A,
    MUL_AREA_B
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     prep;
    logic     div_step;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic compute;
    logic last;
    logic div_last;
    logic out_busy;
  } stat_t;

endpackage

// ===== hw/rtl/biac_ctrl.sv =====
// ----------------------------------------------------------------------------
// biac_ctrl
// Sequencer: capture, three multiplies, union prep, restoring divide, finish.
// ----------------------------------------------------------------------------
module biac_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  biac_pkg::stat_t stat,
  output biac_pkg::cmd_t  cmd
);

  biac_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= biac_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      biac_pkg::ST_IDLE: begin
        if (in_valid) state_next = biac_pkg::ST_MUL_I;
      end
      biac_pkg::ST_MUL_I: begin
        state_next = stat.compute ? biac_pkg::ST_MUL_A : biac_pkg::ST_FINISH;
      end
      biac_pkg::ST_MUL_A: state_next = biac_pkg::ST_MUL_B;
      biac_pkg::ST_MUL_B: state_next = biac_pkg::ST_PREP;
      biac_pkg::ST_PREP:  state_next = biac_pkg::ST_DIV;
      biac_pkg::ST_DIV: begin
        if (stat.div_last) state_next = biac_pkg::ST_FINISH;
      end
      biac_pkg::ST_FINISH: begin
        if (!(stat.last && stat.out_busy)) state_next = biac_pkg::ST_IDLE;
      end
      default: state_next = biac_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.mul_sel  = biac_pkg::MUL_INTER;
    case (state)
      biac_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      biac_pkg::ST_MUL_I: begin
        cmd.mul_en  = stat.compute;
        cmd.mul_sel = biac_pkg::MUL_INTER;
      end
      biac_pkg::ST_MUL_A: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = biac_pkg::MUL_AREA_A;
      end
      biac_pkg::ST_MUL_B: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = biac_pkg::MUL_AREA_B;
      end
      biac_pkg::ST_PREP:   cmd.prep     = 1'b1;
      biac_pkg::ST_DIV:    cmd.div_step = 1'b1;
      biac_pkg::ST_FINISH: cmd.finish   = !(stat.last && stat.out_busy);
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hw/rtl/biac_datapath.sv =====
// ----------------------------------------------------------------------------
// biac_datapath
// Box geometry, shared multiplier, restoring divider, counters, output beat.
// ----------------------------------------------------------------------------
module biac_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [biac_pkg::PCT_BITS-1:0] cfg_data,
  input  logic [biac_pkg::IN_BITS-1:0]  in_data,
  input  logic                          in_last,
  input  biac_pkg::cmd_t                cmd,
  output biac_pkg::stat_t               stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [biac_pkg::OUT_BITS-1:0] out_data
);

  localparam int CB = biac_pkg::CB;
  localparam int PB = biac_pkg::PCT_BITS;
  localparam int NB = biac_pkg::CNT_BITS;
  localparam int RB = biac_pkg::REM_BITS;

  // input slices
  biac_pkg::coord_t lab_l, lab_t, lab_r, lab_b, cnd_l, cnd_t, cnd_r, cnd_b;
  biac_pkg::coord_t il, it, ir, ib;
  logic             overlap;

  assign lab_l = in_data[0*CB +: CB];
  assign lab_t = in_data[1*CB +: CB];
  assign lab_r = in_data[2*CB +: CB];
  assign lab_b = in_data[3*CB +: CB];
  assign cnd_l = in_data[4*CB +: CB];
  assign cnd_t = in_data[5*CB +: CB];
  assign cnd_r = in_data[6*CB +: CB];
  assign cnd_b = in_data[7*CB +: CB];

  assign il = (lab_l > cnd_l) ? lab_l : cnd_l;
  assign it = (lab_t > cnd_t) ? lab_t : cnd_t;
  assign ir = (lab_r < cnd_r) ? lab_r : cnd_r;
  assign ib = (lab_b < cnd_b) ? lab_b : cnd_b;
  assign overlap = (il < ir) && (it < ib);

  // spans are positive whenever the boxes overlap, so CB bits hold them
  biac_pkg::span_t iw, ih, aw, ah, bw, bh;
  logic            compute, last;
  logic            list_ended;

  biac_pkg::area_t inter, area_a, area_b;
  biac_pkg::span_t op_x, op_y;
  biac_pkg::area_t product;

  logic [biac_pkg::UNI_BITS-1:0]  uni;
  logic [RB-1:0]                  scaled;
  logic [RB-1:0]                  rem, dvs;
  logic [PB-1:0]                  quo, quo_fin;
  logic [biac_pkg::STEP_BITS-1:0] step;
  logic                           ge;

  logic [PB-1:0] running_best;
  logic [PB-1:0] threshold;
  logic [NB-1:0] hit_count, image_count, hit_count_next, image_count_next;
  logic          hit;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      iw <= biac_pkg::span_t'(ir - il);
      ih <= biac_pkg::span_t'(ib - it);
      aw <= biac_pkg::span_t'(lab_r - lab_l);
      ah <= biac_pkg::span_t'(lab_b - lab_t);
      bw <= biac_pkg::span_t'(cnd_r - cnd_l);
      bh <= biac_pkg::span_t'(cnd_b - cnd_t);
    end
  end

  // shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      biac_pkg::MUL_INTER: begin
        op_x = iw;
        op_y = ih;
      end
      biac_pkg::MUL_AREA_A: begin
        op_x = aw;
        op_y = ah;
      end
      biac_pkg::MUL_AREA_B: begin
        op_x = bw;
        op_y = bh;
      end
      default: begin
        op_x = iw;
        op_y = ih;
      end
    endcase
  end

  assign product = biac_pkg::area_t'(op_x) * biac_pkg::area_t'(op_y);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        biac_pkg::MUL_INTER:  inter  <= product;
        biac_pkg::MUL_AREA_A: area_a <= product;
        biac_pkg::MUL_AREA_B: area_b <= product;
        default:              inter  <= product;
      endcase
    end
  end

  assign uni    = biac_pkg::UNI_BITS'(area_a) + biac_pkg::UNI_BITS'(area_b)
                - biac_pkg::UNI_BITS'(inter);
  assign scaled = RB'(inter) * RB'(biac_pkg::PCT_SCALE);

  // restoring divide, quotient bit from the top down
  assign ge      = rem >= dvs;
  assign quo_fin = {quo[PB-2:0], ge};

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      rem  <= scaled;
      dvs  <= {uni, {(PB-1){1'b0}}};
      quo  <= '0;
      step <= '0;
    end else if (cmd.div_step) begin
      if (ge) rem <= rem - dvs;
      dvs  <= dvs >> 1;
      quo  <= quo_fin;
      step <= step + 1'b1;
    end
  end

  assign hit              = running_best >= threshold;
  assign hit_count_next   = (hit && (hit_count != '1)) ? hit_count + 1'b1 : hit_count;
  assign image_count_next = (image_count != '1) ? image_count + 1'b1 : image_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= PB'(biac_pkg::THR_RESET);
      running_best <= '0;
      list_ended   <= 1'b0;
      hit_count    <= '0;
      image_count  <= '0;
      compute      <= 1'b0;
      last         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) threshold <= cfg_data;
      if (out_ready) out_valid <= 1'b0;
      if (cmd.capture) begin
        compute <= !list_ended && (cnd_l != '0) && overlap;
        last    <= in_last;
        if (!list_ended && (cnd_l == '0)) list_ended <= 1'b1;
      end
      if (cmd.div_step && stat.div_last && (quo_fin > running_best)) begin
        running_best <= quo_fin;
      end
      if (cmd.finish && last) begin
        hit_count    <= hit_count_next;
        image_count  <= image_count_next;
        running_best <= '0;
        list_ended   <= 1'b0;
        out_valid    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && last) begin
      out_data <= biac_pkg::OUT_BITS'({image_count_next, hit_count_next, hit, running_best});
    end
  end

  assign stat.compute  = compute;
  assign stat.last     = last;
  assign stat.div_last = cmd.div_step &&
                         (step == biac_pkg::STEP_BITS'(biac_pkg::DIV_STEPS - 1));
  assign stat.out_busy = out_valid && !out_ready;

endmodule

// ===== hw/rtl/box_iou_accuracy_counter.sv =====
// Sequence for an overlapping candidate, from the input beat to the result:
// capture, three shared-multiplier passes, union prep, seven restoring-divide
// steps, finish; when no IoU is needed, capture, the intersection state, finish.
// One candidate at a time: a new one is taken only back in idle after finish;
// a last candidate also holds in finish while the previous result waits.
// Reset (rst, synchronous): threshold back to 50, counters cleared, no result.
// ----------------------------------------------------------------------------
// box_iou_accuracy_counter
// Tracks best percent IoU per image and keeps saturating hit/image counts.
// ----------------------------------------------------------------------------
`include "box_iou_accuracy_counter_defines.svh"

module box_iou_accuracy_counter (
  input  logic                          clk,
  input  logic                          rst,
  // threshold register write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [biac_pkg::PCT_BITS-1:0] cfg_data,
  // candidate beats
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata, lowest first: label_left, label_top, label_right, label_bottom,
  // cand_left, cand_top, cand_right, cand_bottom
  input  logic [biac_pkg::IN_BITS-1:0]  s_axis_tdata,
  input  logic                          s_axis_tlast,   // last_candidate
  // result beats
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata, lowest first: best_iou[6:0], hit, hits_so_far[31:0],
  // images_so_far[31:0]
  output logic [biac_pkg::OUT_BITS-1:0] m_axis_tdata
);

  biac_pkg::cmd_t  cmd;
  biac_pkg::stat_t stat;

  // Configuration is to be written only while idle; the block itself does not enforce this, so take it on every beat.
  assign cfg_ready = 1'b1;

  // Controller: one candidate in flight, sequenced step by step.
  biac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: geometry, areas, divide, counters and the output register that
  // decouples a waiting result from the next candidate.
  biac_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  // One candidate at a time: ready drops after each accepted beat.
  `BIAC_ASSERT_NXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second beat taken mid-sequence")

  // Finishing the last candidate must present a result.
  `BIAC_ASSERT_NXT(a_emit, cmd.finish && stat.last, m_axis_tvalid, "result not presented")

  // Percent IoU never exceeds 100.
  `BIAC_ASSERT_IMP(a_pct_range, m_axis_tvalid, m_axis_tdata[6:0] <= 7'd100, "best_iou above 100")

  // Hits can never outnumber images judged.
  `BIAC_ASSERT_IMP(a_hits_le_images, m_axis_tvalid, m_axis_tdata[39:8] <= m_axis_tdata[71:40], "hit count above image count")

endmodule
